// ===== design/bcss_pkg.sv =====
// ----------------------------------------------------------------------------
// bcss_pkg
// Shared types, codes and constants of the breath cycle servo sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bcss_pkg;

  // Default full-scale count of the ADC readings
  localparam int unsigned ADC_FULL_SCALE_DEF = 4096;

  // Numerator of the breath period, in ms per minute
  localparam logic [15:0] PERIOD_BASE = 16'd60000;

  // Largest angle the servo accepts
  localparam logic [7:0] ANGLE_LIMIT = 8'd180;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SERVO  = 2'd1,
    KIND_IDLE   = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  // Input operations
  typedef enum logic [1:0] {
    OP_BUTTON  = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // Register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_PRESSURE_MAX    = 3'd0,
    REG_PRESSURE_MIN    = 3'd1,
    REG_RATE_MAX        = 3'd2,
    REG_RATE_MIN        = 3'd3,
    REG_SWEEP_ANGLE_MAX = 3'd4,
    REG_SWEEP_ANGLE_MIN = 3'd5
  } reg_idx_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_LAUNCH,
    S_WAIT,
    S_POST,
    S_RESULT
  } seq_state_t;

  // Which division the shared divider is working on
  typedef enum logic [3:0] {
    D_PDIV,
    D_RDIV,
    D_STEP,
    D_PV,
    D_RQ,
    D_PER,
    D_TI,
    D_DUP,
    D_DDN
  } div_sel_t;

  // Configuration register contents
  typedef struct packed {
    logic [11:0] pressure_max;
    logic [11:0] pressure_min;
    logic [11:0] rate_max;
    logic [11:0] rate_min;
    logic [7:0]  sweep_angle_max;
    logic [7:0]  sweep_angle_min;
  } cfg_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [1:0]  mode;
    logic [7:0]  servo_angle;
    logic [15:0] dwell_ms;
    logic        last_step;
    logic [12:0] pressure_level;
    logic [12:0] rate_bpm;
    logic [15:0] period_ms;
    logic [2:0]  exhale_ratio;
  } res_t;

  // Divider width: room for the full-scale count and for the period base
  function automatic int unsigned div_width(input int unsigned afs);
    int unsigned w;
    w = $clog2(afs + 1);
    return (w > 16) ? w : 16;
  endfunction

endpackage

`default_nettype wire

// ===== design/bcss_div.sv =====
// ----------------------------------------------------------------------------
// bcss_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bcss_div #(
  parameter int unsigned W = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     dvs_r, dvs_nxt;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;

  // Trial subtract of the shifted remainder
  assign rem_sh = {rem_r, quo_r[W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[W]) begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath flops
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/bcss_cfg.sv =====
// ----------------------------------------------------------------------------
// bcss_cfg
// APB-style configuration registers: ranges of the readings and sweep angles.
// ----------------------------------------------------------------------------
`default_nettype none

module bcss_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output bcss_pkg::cfg_t     cfg_o
);

  import bcss_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // Register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PRESSURE_MAX:    cfg_nxt.pressure_max    = pwdata[11:0];
        REG_PRESSURE_MIN:    cfg_nxt.pressure_min    = pwdata[11:0];
        REG_RATE_MAX:        cfg_nxt.rate_max        = pwdata[11:0];
        REG_RATE_MIN:        cfg_nxt.rate_min        = pwdata[11:0];
        REG_SWEEP_ANGLE_MAX: cfg_nxt.sweep_angle_max = pwdata[7:0];
        REG_SWEEP_ANGLE_MIN: cfg_nxt.sweep_angle_min = pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_PRESSURE_MAX:    prdata = {20'd0, cfg_r.pressure_max};
      REG_PRESSURE_MIN:    prdata = {20'd0, cfg_r.pressure_min};
      REG_RATE_MAX:        prdata = {20'd0, cfg_r.rate_max};
      REG_RATE_MIN:        prdata = {20'd0, cfg_r.rate_min};
      REG_SWEEP_ANGLE_MAX: prdata = {24'd0, cfg_r.sweep_angle_max};
      REG_SWEEP_ANGLE_MIN: prdata = {24'd0, cfg_r.sweep_angle_min};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pressure_max    <= 12'd60;
      cfg_r.pressure_min    <= 12'd15;
      cfg_r.rate_max        <= 12'd40;
      cfg_r.rate_min        <= 12'd12;
      cfg_r.sweep_angle_max <= 8'd180;
      cfg_r.sweep_angle_min <= 8'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_r;

endmodule

`default_nettype wire

// ===== design/bcss_core.sv =====
// ----------------------------------------------------------------------------
// bcss_core
// Sequencer: mode, sweep state and the chain of divisions of a start item.
// ----------------------------------------------------------------------------
`default_nettype none

module bcss_core #(
  parameter int unsigned ADC_FULL_SCALE = bcss_pkg::ADC_FULL_SCALE_DEF,
  parameter int unsigned DIV_W          = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_operation,
  input  logic [11:0]          in_adc_pressure,
  input  logic [11:0]          in_adc_rate,
  input  bcss_pkg::cfg_t       cfg_i,
  output logic                 div_start,
  output logic [DIV_W-1:0]     div_dividend,
  output logic [DIV_W-1:0]     div_divisor,
  input  logic                 div_done,
  input  logic [DIV_W-1:0]     div_quotient,
  output logic                 res_valid,
  input  logic                 res_take,
  output bcss_pkg::res_t       res_o
);

  import bcss_pkg::*;

  seq_state_t  state_r, state_nxt;
  div_sel_t    dsel_r, dsel_nxt;

  // Latched item
  logic [1:0]  op_r, op_nxt;
  logic [11:0] adcp_r, adcp_nxt;
  logic [11:0] adcr_r, adcr_nxt;

  // Architectural state
  logic [1:0]  mode_r, mode_nxt;
  logic [2:0]  exh_r, exh_nxt;
  logic        active_r, active_nxt;
  logic        down_r, down_nxt;
  logic [8:0]  cur_r, cur_nxt;
  logic [8:0]  top_r, top_nxt;
  logic [8:0]  step_r, step_nxt;
  logic [15:0] dwu_r, dwu_nxt;
  logic [15:0] dwd_r, dwd_nxt;

  // Start intermediates
  logic [DIV_W-1:0] pdiv_r, pdiv_nxt;
  logic [DIV_W-1:0] rdiv_r, rdiv_nxt;
  logic [7:0]  stp_r, stp_nxt;
  logic [11:0] pv_r, pv_nxt;
  logic [12:0] rv_r, rv_nxt;
  logic [15:0] per_r, per_nxt;
  logic [15:0] ti_r, ti_nxt;
  logic [15:0] te_r, te_nxt;
  logic [7:0]  topc_r, topc_nxt;

  // Result fields
  kind_t       rk_r, rk_nxt;
  logic [7:0]  rang_r, rang_nxt;
  logic [15:0] rdw_r, rdw_nxt;
  logic        rlast_r, rlast_nxt;
  logic [12:0] rpl_r, rpl_nxt;
  logic [12:0] rrb_r, rrb_nxt;
  logic [15:0] rper_r, rper_nxt;

  // Derived conditions
  logic [11:0] dp, dr;
  logic [7:0]  da;
  logic        range_bad, zero_bad, rv_zero, top_low, up_turn, last_dn;
  logic [19:0] top_prod;
  logic [2:0]  e_val;
  logic [7:0]  ang_clamp;

  assign dp        = cfg_i.pressure_max - cfg_i.pressure_min;
  assign dr        = cfg_i.rate_max - cfg_i.rate_min;
  assign da        = cfg_i.sweep_angle_max - cfg_i.sweep_angle_min;
  assign range_bad = (cfg_i.pressure_max <= cfg_i.pressure_min) ||
                     (cfg_i.rate_max <= cfg_i.rate_min) ||
                     (cfg_i.sweep_angle_max < cfg_i.sweep_angle_min);
  assign zero_bad  = (pdiv_r == '0) || (rdiv_r == '0) || (stp_r == 8'd0);
  assign rv_zero   = (rv_r == 13'd0);
  assign top_low   = (topc_r < cfg_i.sweep_angle_min);
  assign up_turn   = ({1'b0, cur_r} + {1'b0, step_r}) > {1'b0, top_r};
  assign last_dn   = {1'b0, cur_r} < ({2'b0, cfg_i.sweep_angle_min} + {1'b0, step_r});
  assign top_prod  = pv_r * stp_r;
  assign e_val     = {1'b0, mode_r} + 3'd1;
  assign ang_clamp = (cur_r > {1'b0, ANGLE_LIMIT}) ? ANGLE_LIMIT : cur_r[7:0];

  // Divider operand select
  always_comb begin
    unique case (dsel_r)
      D_PDIV: begin
        div_dividend = DIV_W'(ADC_FULL_SCALE);
        div_divisor  = DIV_W'(dp);
      end
      D_RDIV: begin
        div_dividend = DIV_W'(ADC_FULL_SCALE);
        div_divisor  = DIV_W'(dr);
      end
      D_STEP: begin
        div_dividend = DIV_W'(da);
        div_divisor  = DIV_W'(dp);
      end
      D_PV: begin
        div_dividend = DIV_W'(adcp_r);
        div_divisor  = pdiv_r;
      end
      D_RQ: begin
        div_dividend = DIV_W'(adcr_r);
        div_divisor  = rdiv_r;
      end
      D_PER: begin
        div_dividend = DIV_W'(PERIOD_BASE);
        div_divisor  = DIV_W'(rv_r);
      end
      D_TI: begin
        div_dividend = DIV_W'(per_r);
        div_divisor  = DIV_W'(e_val + 3'd1);
      end
      D_DUP: begin
        div_dividend = DIV_W'(ti_r);
        div_divisor  = DIV_W'(pv_r);
      end
      D_DDN: begin
        div_dividend = DIV_W'(te_r);
        div_divisor  = DIV_W'(pv_r);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if ((op_r == OP_START) && !range_bad) state_nxt = S_LAUNCH;
        else                                  state_nxt = S_RESULT;
      end
      S_LAUNCH: state_nxt = S_WAIT;
      S_WAIT:   if (div_done) state_nxt = S_POST;
      S_POST: begin
        unique case (dsel_r)
          D_STEP:  state_nxt = zero_bad ? S_RESULT : S_LAUNCH;
          D_RQ:    state_nxt = rv_zero ? S_RESULT : S_LAUNCH;
          D_PER:   state_nxt = (mode_r == 2'd0) ? S_RESULT : S_LAUNCH;
          D_TI:    state_nxt = top_low ? S_RESULT : S_LAUNCH;
          D_DDN:   state_nxt = S_RESULT;
          default: state_nxt = S_LAUNCH;
        endcase
      end
      S_RESULT: if (res_take) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    logic [1:0] mode_inc;
    mode_inc   = mode_r + 2'd1;
    dsel_nxt   = dsel_r;
    op_nxt     = op_r;
    adcp_nxt   = adcp_r;
    adcr_nxt   = adcr_r;
    mode_nxt   = mode_r;
    exh_nxt    = exh_r;
    active_nxt = active_r;
    down_nxt   = down_r;
    cur_nxt    = cur_r;
    top_nxt    = top_r;
    step_nxt   = step_r;
    dwu_nxt    = dwu_r;
    dwd_nxt    = dwd_r;
    pdiv_nxt   = pdiv_r;
    rdiv_nxt   = rdiv_r;
    stp_nxt    = stp_r;
    pv_nxt     = pv_r;
    rv_nxt     = rv_r;
    per_nxt    = per_r;
    ti_nxt     = ti_r;
    te_nxt     = te_r;
    topc_nxt   = topc_r;
    rk_nxt     = rk_r;
    rang_nxt   = rang_r;
    rdw_nxt    = rdw_r;
    rlast_nxt  = rlast_r;
    rpl_nxt    = rpl_r;
    rrb_nxt    = rrb_r;
    rper_nxt   = rper_r;
    div_start  = 1'b0;

    unique case (state_r)
      // Take the item
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          adcp_nxt = in_adc_pressure;
          adcr_nxt = in_adc_rate;
        end
      end

      // Button, advance and unused codes, and the range check of a start
      S_EXEC: begin
        rk_nxt    = KIND_STATUS;
        rang_nxt  = 8'd0;
        rdw_nxt   = 16'd0;
        rlast_nxt = 1'b0;
        rpl_nxt   = 13'd0;
        rrb_nxt   = 13'd0;
        rper_nxt  = 16'd0;
        unique case (op_r)
          OP_BUTTON: begin
            mode_nxt = mode_inc;
            if (mode_inc != 2'd0) exh_nxt = {1'b0, mode_inc} + 3'd1;
          end
          OP_START: begin
            active_nxt = 1'b0;
            dsel_nxt   = D_PDIV;
            if (range_bad) rk_nxt = KIND_ERROR;
          end
          OP_ADVANCE: begin
            if (!active_r) begin
              rk_nxt = KIND_IDLE;
            end else begin
              rk_nxt   = KIND_SERVO;
              rang_nxt = ang_clamp;
              if (!down_r) begin
                rdw_nxt = dwu_r;
                if (up_turn) begin
                  down_nxt = 1'b1;
                  cur_nxt  = top_r;
                end else begin
                  cur_nxt = cur_r + step_r;
                end
              end else begin
                rdw_nxt = dwd_r;
                if (last_dn) begin
                  rlast_nxt  = 1'b1;
                  active_nxt = 1'b0;
                  down_nxt   = 1'b0;
                end else begin
                  cur_nxt = cur_r - step_r;
                end
              end
            end
          end
          default: rk_nxt = KIND_IDLE;
        endcase
      end

      S_LAUNCH: div_start = 1'b1;

      // Capture the quotient
      S_WAIT: begin
        if (div_done) begin
          unique case (dsel_r)
            D_PDIV: pdiv_nxt = div_quotient;
            D_RDIV: rdiv_nxt = div_quotient;
            D_STEP: stp_nxt  = div_quotient[7:0];
            D_PV:   pv_nxt   = (div_quotient[11:0] == 12'd0) ? 12'd1 : div_quotient[11:0];
            D_RQ:   rv_nxt   = {1'b0, div_quotient[11:0]} + {1'b0, cfg_i.rate_min};
            D_PER:  per_nxt  = div_quotient[15:0];
            D_TI:   ti_nxt   = div_quotient[15:0];
            D_DUP:  dwu_nxt  = div_quotient[15:0];
            D_DDN:  dwd_nxt  = div_quotient[15:0];
            default: ;
          endcase
        end
      end

      // Checks between divisions, pick the next one
      S_POST: begin
        unique case (dsel_r)
          D_PDIV: dsel_nxt = D_RDIV;
          D_RDIV: dsel_nxt = D_STEP;
          D_STEP: begin
            if (zero_bad) rk_nxt = KIND_ERROR;
            else          dsel_nxt = D_PV;
          end
          D_PV:   dsel_nxt = D_RQ;
          D_RQ: begin
            if (rv_zero) begin
              rk_nxt = KIND_ERROR;
            end else begin
              topc_nxt = (top_prod > {12'd0, cfg_i.sweep_angle_max}) ?
                         cfg_i.sweep_angle_max : top_prod[7:0];
              dsel_nxt = D_PER;
            end
          end
          D_PER: begin
            rpl_nxt  = {1'b0, pv_r} + {1'b0, cfg_i.pressure_min};
            rrb_nxt  = rv_r;
            rper_nxt = per_r;
            if (mode_r != 2'd0) begin
              exh_nxt  = e_val;
              dsel_nxt = D_TI;
            end
          end
          D_TI: begin
            te_nxt = 16'(ti_r * e_val);
            if (!top_low) dsel_nxt = D_DUP;
          end
          D_DUP: dsel_nxt = D_DDN;
          D_DDN: begin
            // Arm the sweep
            top_nxt    = {1'b0, topc_r};
            step_nxt   = {1'b0, stp_r};
            cur_nxt    = {1'b0, cfg_i.sweep_angle_min};
            down_nxt   = 1'b0;
            active_nxt = 1'b1;
          end
          default: ;
        endcase
      end

      S_RESULT: ;
      default: ;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      dsel_r   <= D_PDIV;
      mode_r   <= 2'd0;
      exh_r    <= 3'd2;
      active_r <= 1'b0;
      down_r   <= 1'b0;
      cur_r    <= 9'd0;
      top_r    <= 9'd0;
      step_r   <= 9'd0;
      dwu_r    <= 16'd0;
      dwd_r    <= 16'd0;
    end else begin
      state_r  <= state_nxt;
      dsel_r   <= dsel_nxt;
      mode_r   <= mode_nxt;
      exh_r    <= exh_nxt;
      active_r <= active_nxt;
      down_r   <= down_nxt;
      cur_r    <= cur_nxt;
      top_r    <= top_nxt;
      step_r   <= step_nxt;
      dwu_r    <= dwu_nxt;
      dwd_r    <= dwd_nxt;
    end
  end

  // Payload flops
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    adcp_r  <= adcp_nxt;
    adcr_r  <= adcr_nxt;
    pdiv_r  <= pdiv_nxt;
    rdiv_r  <= rdiv_nxt;
    stp_r   <= stp_nxt;
    pv_r    <= pv_nxt;
    rv_r    <= rv_nxt;
    per_r   <= per_nxt;
    ti_r    <= ti_nxt;
    te_r    <= te_nxt;
    topc_r  <= topc_nxt;
    rk_r    <= rk_nxt;
    rang_r  <= rang_nxt;
    rdw_r   <= rdw_nxt;
    rlast_r <= rlast_nxt;
    rpl_r   <= rpl_nxt;
    rrb_r   <= rrb_nxt;
    rper_r  <= rper_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RESULT);

  always_comb begin
    res_o.kind           = rk_r;
    res_o.mode           = mode_r;
    res_o.servo_angle    = rang_r;
    res_o.dwell_ms       = rdw_r;
    res_o.last_step      = rlast_r;
    res_o.pressure_level = rpl_r;
    res_o.rate_bpm       = rrb_r;
    res_o.period_ms      = rper_r;
    res_o.exhale_ratio   = exh_r;
  end

endmodule

`default_nettype wire

// ===== design/breath_cycle_servo_sequencer.sv =====
// ----------------------------------------------------------------------------
// Breath cycle servo sequencer
// Usage:
//   Input channel (in_valid/in_ready) takes one item: operation plus two
//   12-bit readings. Result channel (out_valid/out_ready) gives exactly one
//   item back per input item, in order. The APB-style port (psel, penable,
//   pwrite, paddr, pwdata, prdata, pready) holds six range registers at
//   byte addresses 0, 4, ... 20; write them only while the block is idle.
//   Button, advance and unused codes: the sequencer passes through its
//   execute and result states; the next item is taken after the result
//   moves to the output register. Start: up to nine divisions on one
//   shared bit-serial divider (DIV_W = 16 at the default full scale),
//   each launched, waited on and checked in turn; fewer when a check
//   ends it early.
//   One item at a time: in_ready is high only while the sequencer is idle.
//   The finished result waits in the output register; a new item is taken
//   meanwhile, and its own result holds in the sequencer until out_ready.
//   Reset (rst_n low, synchronous) restores register defaults, mode off,
//   exhale ratio 2 and no sweep; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module breath_cycle_servo_sequencer #(
  parameter int unsigned ADC_FULL_SCALE = bcss_pkg::ADC_FULL_SCALE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [11:0] in_adc_pressure,
  input  logic [11:0] in_adc_rate,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_mode,
  output logic [7:0]  out_servo_angle,
  output logic [15:0] out_dwell_ms,
  output logic        out_last_step,
  output logic [12:0] out_pressure_level,
  output logic [12:0] out_rate_bpm,
  output logic [15:0] out_period_ms,
  output logic [2:0]  out_exhale_ratio,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import bcss_pkg::*;

  localparam int unsigned DIV_W = div_width(ADC_FULL_SCALE);

  cfg_t             cfg;
  res_t             res;
  logic             res_valid;
  logic             res_take;
  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] div_dividend;
  logic [DIV_W-1:0] div_divisor;
  logic [DIV_W-1:0] div_quotient;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_r;

  bcss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcss_div #(
    .W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  bcss_core #(
    .ADC_FULL_SCALE (ADC_FULL_SCALE),
    .DIV_W          (DIV_W)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_adc_pressure (in_adc_pressure),
    .in_adc_rate     (in_adc_rate),
    .cfg_i           (cfg),
    .div_start       (div_start),
    .div_dividend    (div_dividend),
    .div_divisor     (div_divisor),
    .div_done        (div_done),
    .div_quotient    (div_quotient),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res_o           (res)
  );

  // Output register: loads when empty or being drained
  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_take) out_valid_nxt = 1'b1;
    else if (out_ready)        out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) out_r <= res;
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_mode           = out_r.mode;
  assign out_servo_angle    = out_r.servo_angle;
  assign out_dwell_ms       = out_r.dwell_ms;
  assign out_last_step      = out_r.last_step;
  assign out_pressure_level = out_r.pressure_level;
  assign out_rate_bpm       = out_r.rate_bpm;
  assign out_period_ms      = out_r.period_ms;
  assign out_exhale_ratio   = out_r.exhale_ratio;

`ifndef NO_ASSERTIONS
  // Sequencer goes busy once an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer still ready after taking an item");

  // A finished result is held while the output register is full
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid)
    else $error("result dropped while output stalled");

  // Only servo writes carry an angle, dwell or last-step flag
  a_servo_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_SERVO) |->
      (out_servo_angle == 8'd0) && (out_dwell_ms == 16'd0) && !out_last_step)
    else $error("servo fields set on a non-servo result");

  // No divider launch while a quotient is being handed back
  a_div_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> !div_start)
    else $error("divider restarted while finishing");
`endif

endmodule

`default_nettype wire
